// File: rtl/core/s2a_pkg.sv
// ----------------------------------------------------------------------------
// s2a_pkg
// Shared types, constants and the set-1 scancode translation table for the
// scancode to ASCII character ring.
// ----------------------------------------------------------------------------
package s2a_pkg;

    localparam int RING_DEPTH = 64;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CODE_W     = 8;
    localparam int CHAR_W     = 7;
    localparam int OUT_DATA_W = 24;

    localparam logic [CODE_W-1:0] CODE_CTRL_DOWN = 8'h1D;
    localparam logic [CODE_W-1:0] CODE_CTRL_UP   = 8'h9D;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_C   = 7'h63;

    typedef enum logic {
        ACT_SCANCODE = 1'b0,
        ACT_READ     = 1'b1
    } action_t;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } s2a_state_t;

    typedef logic [PTR_W-1:0] ptr_t;

    function automatic ptr_t ptr_advance(input ptr_t p);
        ptr_t r;
        if (p == ptr_t'(RING_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

    // Set-1 make codes to ASCII; unmapped, release and out-of-range codes give zero.
    function automatic logic [CHAR_W-1:0] ascii_lookup(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] c;
        unique case (code)
            8'h02: c = 7'h31;
            8'h03: c = 7'h32;
            8'h04: c = 7'h33;
            8'h05: c = 7'h34;
            8'h06: c = 7'h35;
            8'h07: c = 7'h36;
            8'h08: c = 7'h37;
            8'h09: c = 7'h38;
            8'h0A: c = 7'h39;
            8'h0B: c = 7'h30;
            8'h0C: c = 7'h2D;
            8'h0D: c = 7'h3D;
            8'h10: c = 7'h71;
            8'h11: c = 7'h77;
            8'h12: c = 7'h65;
            8'h13: c = 7'h72;
            8'h14: c = 7'h74;
            8'h15: c = 7'h79;
            8'h16: c = 7'h75;
            8'h17: c = 7'h69;
            8'h18: c = 7'h6F;
            8'h19: c = 7'h70;
            8'h1A: c = 7'h5B;
            8'h1B: c = 7'h5D;
            8'h1C: c = 7'h0A;
            8'h1E: c = 7'h61;
            8'h1F: c = 7'h73;
            8'h20: c = 7'h64;
            8'h21: c = 7'h66;
            8'h22: c = 7'h67;
            8'h23: c = 7'h68;
            8'h24: c = 7'h6A;
            8'h25: c = 7'h6B;
            8'h26: c = 7'h6C;
            8'h27: c = 7'h3B;
            8'h28: c = 7'h27;
            8'h29: c = 7'h60;
            8'h2B: c = 7'h5C;
            8'h2C: c = 7'h7A;
            8'h2D: c = 7'h78;
            8'h2E: c = 7'h63;
            8'h2F: c = 7'h76;
            8'h30: c = 7'h62;
            8'h31: c = 7'h6E;
            8'h32: c = 7'h6D;
            8'h33: c = 7'h2C;
            8'h34: c = 7'h2E;
            8'h35: c = 7'h2F;
            8'h37: c = 7'h2A;
            8'h39: c = 7'h20;
            8'h47: c = 7'h37;
            8'h48: c = 7'h38;
            8'h49: c = 7'h39;
            8'h4A: c = 7'h2D;
            8'h4B: c = 7'h34;
            8'h4C: c = 7'h35;
            8'h4D: c = 7'h36;
            8'h4E: c = 7'h2B;
            8'h4F: c = 7'h31;
            8'h50: c = 7'h32;
            8'h51: c = 7'h33;
            8'h52: c = 7'h30;
            8'h53: c = 7'h2E;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/scancode_to_ascii_fifo.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo
// Translates set-1 keyboard scancodes to ASCII, tracks left Ctrl, flags
// Ctrl+C and queues typed characters in a ring that is read back on request.
// ----------------------------------------------------------------------------
// A scancode item is translated and written into the ring as it is taken, and
// its result is registered in the output register. A read item on a non-empty
// ring is read from the synchronous ring memory into mem_rdata_reg and passes
// through ST_POP before its result is registered; on an empty ring its zero
// result is registered directly. The ring has RING_DEPTH entries and holds at
// most RING_DEPTH-1 characters. A new item is taken once the output register
// is empty or in the cycle that its result leaves, except during a pop.
module scancode_to_ascii_fifo
    import s2a_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [CODE_W-1:0]     s_tdata,   // [7:0] scancode
    input  logic                  s_tuser,   // [0] action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [6:0] read_char, [7] echo_valid, [14:8] echo_char, [15] interrupt_raised,
    // [16] char_dropped, [23:17] zero
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic [CHAR_W-1:0] ring [RING_DEPTH];

    s2a_state_t            state_reg, state_next;
    ptr_t                  wr_ptr_reg, wr_ptr_next;
    ptr_t                  rd_ptr_reg, rd_ptr_next;
    logic                  ctrl_down_reg, ctrl_down_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [CHAR_W-1:0]     mem_rdata_reg;

    logic              accept;
    logic              is_read;
    logic              ring_empty;
    logic              ring_full;
    logic [CHAR_W-1:0] ch;
    logic              mem_we;
    logic              mem_re;
    logic              out_free;

    assign out_free   = !out_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign is_read    = (action_t'(s_tuser) == ACT_READ);
    assign ring_empty = (wr_ptr_reg == rd_ptr_reg);
    assign ring_full  = (ptr_advance(wr_ptr_reg) == rd_ptr_reg);
    assign ch         = ascii_lookup(s_tdata);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && is_read && !ring_empty) begin
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready       = (state_reg == ST_IDLE) && out_free;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        ctrl_down_next = ctrl_down_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (is_read) begin
                        if (ring_empty) begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                        end else begin
                            mem_re      = 1'b1;
                            rd_ptr_next = ptr_advance(rd_ptr_reg);
                        end
                    end else begin
                        out_valid_next = 1'b1;
                        out_data_next  = '0;
                        priority if (s_tdata == CODE_CTRL_DOWN) begin
                            ctrl_down_next = 1'b1;
                        end else if (s_tdata == CODE_CTRL_UP) begin
                            ctrl_down_next = 1'b0;
                        end else if (ch == '0) begin
                            out_data_next = '0;
                        end else if (ctrl_down_reg && ch == CHAR_LOWER_C) begin
                            out_data_next[15] = 1'b1;
                        end else begin
                            out_data_next[7]    = 1'b1;
                            out_data_next[14:8] = ch;
                            if (ring_full) begin
                                out_data_next[16] = 1'b1;
                            end else begin
                                mem_we      = 1'b1;
                                wr_ptr_next = ptr_advance(wr_ptr_reg);
                            end
                        end
                    end
                end
            end
            ST_POP: begin
                out_valid_next     = 1'b1;
                out_data_next      = '0;
                out_data_next[6:0] = mem_rdata_reg;
            end
            default: begin
                out_valid_next = out_valid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            ctrl_down_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            ctrl_down_reg <= ctrl_down_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring[wr_ptr_reg] <= ch;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            mem_rdata_reg <= ring[rd_ptr_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: tb/tb_scancode_to_ascii_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scancode_to_ascii_fifo
// Drives scancode and read items into the keyboard character ring and checks
// every result against a cycle-free model of the key map, the Ctrl state and
// the 63-character ring, with random idling on both sides of the block.
// ----------------------------------------------------------------------------
module tb_scancode_to_ascii_fifo;
    import s2a_pkg::*;

    localparam int KEY_COUNT   = 88;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 16;

    // Set-1 key map, entry 0 first.
    localparam logic [KEY_COUNT*8-1:0] KEYMAP = {
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h00,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [CODE_W-1:0] KEY_C     = 8'h2E;
    localparam logic [CODE_W-1:0] KEY_Q     = 8'h10;
    localparam logic [CODE_W-1:0] KEY_ONE   = 8'h02;
    localparam logic [CODE_W-1:0] KEY_DOT   = 8'h53;
    localparam logic [CODE_W-1:0] KEY_ENTER = 8'h1C;
    localparam logic [CODE_W-1:0] KEY_SPACE = 8'h39;

    typedef struct packed {
        logic [CHAR_W-1:0] read_char;
        logic              echo_valid;
        logic [CHAR_W-1:0] echo_char;
        logic              interrupt_raised;
        logic              char_dropped;
    } key_result_t;

    class key_ring_tracker;
        key_result_t       expected_results[$];
        logic [CHAR_W-1:0] ring_mem[RING_DEPTH];
        ptr_t              wr_ptr;
        ptr_t              rd_ptr;
        bit                ctrl_down;
        int                error_count;

        function new();
            wr_ptr      = '0;
            rd_ptr      = '0;
            ctrl_down   = 1'b0;
            error_count = 0;
        endfunction

        static function logic [CHAR_W-1:0] char_of(input logic [CODE_W-1:0] code);
            if (int'(code) >= KEY_COUNT) begin
                return '0;
            end
            return KEYMAP[8*(KEY_COUNT-1-int'(code)) +: CHAR_W];
        endfunction

        static function ptr_t next_slot(input ptr_t p);
            return ptr_t'((int'(p) + 1) % RING_DEPTH);
        endfunction

        function void note_item(input action_t act, input logic [CODE_W-1:0] code);
            key_result_t       r;
            logic [CHAR_W-1:0] ch;
            ptr_t              nxt;
            r = '0;
            if (act == ACT_READ) begin
                if (wr_ptr != rd_ptr) begin
                    r.read_char = ring_mem[rd_ptr];
                    rd_ptr = next_slot(rd_ptr);
                end
            end else if (code == CODE_CTRL_DOWN) begin
                ctrl_down = 1'b1;
            end else if (code == CODE_CTRL_UP) begin
                ctrl_down = 1'b0;
            end else begin
                ch = char_of(code);
                if (ch != '0) begin
                    if (ctrl_down && ch == CHAR_LOWER_C) begin
                        r.interrupt_raised = 1'b1;
                    end else begin
                        nxt = next_slot(wr_ptr);
                        if (nxt != rd_ptr) begin
                            ring_mem[wr_ptr] = ch;
                            wr_ptr = nxt;
                        end else begin
                            r.char_dropped = 1'b1;
                        end
                        r.echo_valid = 1'b1;
                        r.echo_char  = ch;
                    end
                end
            end
            expected_results.push_back(r);
        endfunction

        task report_mismatch(input string what, input int unsigned want,
                             input int unsigned got);
            $display("%0t ns: mismatch on %s, expected 0x%0h, got 0x%0h",
                     $realtime, what, want, got);
            error_count++;
        endtask

        task check_item(input logic [OUT_DATA_W-1:0] d);
            key_result_t e;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 0, d);
                return;
            end
            e = expected_results.pop_front();
            if (d[6:0] !== e.read_char)
                report_mismatch("read_char", e.read_char, d[6:0]);
            if (d[7] !== e.echo_valid)
                report_mismatch("echo_valid", e.echo_valid, d[7]);
            if (d[14:8] !== e.echo_char)
                report_mismatch("echo_char", e.echo_char, d[14:8]);
            if (d[15] !== e.interrupt_raised)
                report_mismatch("interrupt_raised", e.interrupt_raised, d[15]);
            if (d[16] !== e.char_dropped)
                report_mismatch("char_dropped", e.char_dropped, d[16]);
            if (d[23:17] !== '0)
                report_mismatch("padding", 0, d[23:17]);
        endtask
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [CODE_W-1:0]     s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    key_ring_tracker tracker = new();
    int tx_idle_pct    = 19;
    int rx_idle_pct    = 75;
    int rx_hold_cycles = 0;
    int items_sent     = 0;
    int cycle_count    = 0;

    scancode_to_ascii_fifo u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_cycles > 0) begin
            m_tready <= 1'b0;
            rx_hold_cycles <= rx_hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                tracker.check_item(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                tracker.note_item(action_t'(s_tuser), s_tdata);
            end
        end
    end

    task send_item(input action_t act, input logic [CODE_W-1:0] code);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tuser  <= act;
        do @(posedge aclk); while (s_tready !== 1'b1);
        items_sent++;
    endtask

    function automatic logic [CODE_W-1:0] any_key();
        logic [CODE_W-1:0] code;
        do begin
            code = CODE_W'($urandom_range(KEY_COUNT - 1));
        end while (key_ring_tracker::char_of(code) == '0);
        return code;
    endfunction

    task type_keys(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 15) begin
                send_item(ACT_SCANCODE, {1'b1, 7'($urandom)});
            end else begin
                send_item(ACT_SCANCODE, any_key());
            end
        end
    endtask

    task read_chars(input int n);
        for (int i = 0; i < n; i++) begin
            send_item(ACT_READ, CODE_W'($urandom));
        end
    endtask

    task ctrl_chord();
        int n;
        n = $urandom_range(1, 4);
        send_item(ACT_SCANCODE, CODE_CTRL_DOWN);
        for (int i = 0; i < n; i++) begin
            send_item(ACT_SCANCODE, ($urandom_range(1) == 1) ? KEY_C : any_key());
        end
        if ($urandom_range(9) != 0) begin
            send_item(ACT_SCANCODE, CODE_CTRL_UP);
        end
    endtask

    task random_traffic(input int upto);
        int pick;
        while (items_sent < upto) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                type_keys($urandom_range(1, 12));
            end else if (pick < 40) begin
                type_keys($urandom_range(60, 75));
            end else if (pick < 70) begin
                read_chars($urandom_range(1, 12));
            end else if (pick < 75) begin
                read_chars($urandom_range(60, 70));
            end else if (pick < 88) begin
                ctrl_chord();
            end else begin
                send_item(action_t'($urandom_range(1)), CODE_W'($urandom));
            end
        end
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_scancode_to_ascii_fifo failed");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(ACT_READ, 8'hFF);
        send_item(ACT_SCANCODE, 8'h00);
        send_item(ACT_SCANCODE, 8'hFF);
        send_item(ACT_SCANCODE, 8'h58);
        send_item(ACT_SCANCODE, 8'h57);
        send_item(ACT_SCANCODE, 8'h7F);
        send_item(ACT_SCANCODE, KEY_ONE);
        send_item(ACT_SCANCODE, KEY_DOT);
        send_item(ACT_SCANCODE, KEY_ENTER);
        send_item(ACT_SCANCODE, KEY_C);
        send_item(ACT_SCANCODE, CODE_CTRL_DOWN);
        send_item(ACT_SCANCODE, KEY_C);
        send_item(ACT_SCANCODE, KEY_Q);
        send_item(ACT_SCANCODE, CODE_CTRL_UP);
        send_item(ACT_SCANCODE, KEY_C);
        send_item(ACT_SCANCODE, 8'hAE);
        send_item(ACT_SCANCODE, KEY_SPACE);
        for (int i = 0; i < 8; i++) begin
            send_item(ACT_READ, (i % 2 == 0) ? 8'h00 : 8'hFF);
        end

        // Type 72 scancodes into the ring, then drain it past empty with 70 reads.
        type_keys(72);
        read_chars(70);
        random_traffic(300);

        tx_idle_pct = 75;
        rx_idle_pct = 19;
        random_traffic(550);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_cycles <= 300;
        type_keys(40);
        random_traffic(800);
        s_tvalid <= 1'b0;

        while (tracker.expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (tracker.error_count == 0 && tracker.expected_results.size() == 0) begin
            $display("tb_scancode_to_ascii_fifo passed");
        end else begin
            $display("tb_scancode_to_ascii_fifo failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/s2a_pkg.sv
rtl/core/scancode_to_ascii_fifo.sv
tb/tb_scancode_to_ascii_fifo.sv
